// ----- design/deq_pkg.sv -----
`default_nettype none
package deq_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam logic [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic load;
		logic exec;
	} deq_cmd_t;

endpackage
`default_nettype wire

// ----- design/deq_ctrl.sv -----
`default_nettype none
module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	output deq_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign busy     = busy_q;
	assign done     = done_q;
	assign cmd.load = start & ~busy_q;
	assign cmd.exec = (state_q == S_EXEC);

	// The next operation may be taken while the previous result is on the ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/deq_dp.sv -----
`default_nettype none
module deq_dp
	import deq_pkg::*;
#(
	parameter int unsigned SLOTS = 16
)(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire deq_cmd_t            cmd,
	input  wire logic [1:0]          op,
	input  wire logic signed [31:0]  push_value,
	output logic signed [31:0]       pop_value,
	output logic [1:0]               status
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	logic [DATA_W-1:0] mem [SLOTS];

	op_t               op_q;
	logic [DATA_W-1:0] val_q;
	logic [IW-1:0]     front_q;
	logic [IW-1:0]     back_q;
	logic [DATA_W-1:0] rd_q;
	status_t           st_q;

	logic [IW-1:0] front_inc, front_dec, back_inc, back_dec;
	logic          empty, full_back, full_front;
	logic          wr_en;
	logic [IW-1:0] wr_addr, rd_addr;

	assign front_inc  = (front_q == LAST) ? '0 : front_q + IW'(1);
	assign front_dec  = (front_q == '0) ? LAST : front_q - IW'(1);
	assign back_inc   = (back_q == LAST) ? '0 : back_q + IW'(1);
	assign back_dec   = (back_q == '0) ? LAST : back_q - IW'(1);
	assign empty      = (front_q == back_q);
	assign full_back  = (back_inc == front_q);
	assign full_front = (front_dec == back_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = back_q;
		rd_addr = front_q;
		unique case (op_q)
			OP_PUSH_BACK: begin
				wr_en   = cmd.exec & ~full_back;
				wr_addr = back_q;
			end
			OP_PUSH_FRONT: begin
				wr_en   = cmd.exec & ~full_front;
				wr_addr = front_dec;
			end
			OP_POP_FRONT: rd_addr = front_q;
			OP_POP_BACK:  rd_addr = back_dec;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.exec) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.load) begin
			op_q  <= op_t'(op);
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			st_q    <= ST_OK;
		end else if (cmd.exec) begin
			unique case (op_q)
				OP_PUSH_BACK: begin
					if (full_back) begin
						st_q <= ST_OVERFLOW;
					end else begin
						st_q   <= ST_OK;
						back_q <= back_inc;
					end
				end
				OP_PUSH_FRONT: begin
					if (full_front) begin
						st_q <= ST_OVERFLOW;
					end else begin
						st_q    <= ST_OK;
						front_q <= front_dec;
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						st_q <= ST_UNDERFLOW;
					end else begin
						st_q    <= ST_OK;
						front_q <= front_inc;
					end
				end
				OP_POP_BACK: begin
					if (empty) begin
						st_q <= ST_UNDERFLOW;
					end else begin
						st_q   <= ST_OK;
						back_q <= back_dec;
					end
				end
				default: st_q <= ST_OK;
			endcase
		end
	end

	always_comb begin
		if (st_q == ST_UNDERFLOW) begin
			pop_value = signed'(MIN_VALUE);
		end else if (st_q == ST_OK && (op_q == OP_POP_FRONT || op_q == OP_POP_BACK)) begin
			pop_value = signed'(rd_q);
		end else begin
			pop_value = '0;
		end
	end

	assign status = st_q;

endmodule
`default_nettype wire

// ----- design/double_ended_queue_top.sv -----
// Double-ended queue held in a ring memory of SLOTS entries (SLOTS-1 usable).
// Command channel: op and push_value are taken at a rising edge where start is
// high and busy is low. op selects push back, push front, pop front or pop back.
// Result channel: done is high for exactly one cycle with pop_value and status.
// status is ok, overflow (push dropped, queue unchanged) or underflow (nothing
// removed, pop_value is the most negative value). pop_value is zero for pushes.
// The accepting edge moves the controller into its execute state, in which the
// memory access and index update act on the registered command; done rises
// as it moves on to the result state, and the result beat is taken at the edge
// that ends that state. Commands are not taken while busy is high, which the
// controller holds in the execute state; a new command may be taken in the
// same cycle its predecessor's result is on the ports, since busy is low then.
// Reset empties the queue: both indices go to zero, no result is pending.
// Memory contents are not cleared and no clearing pass runs.
// The receiver cannot stall: each result beat is valid only while done is high.
`default_nettype none
module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int unsigned SLOTS = 16
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         op,
	input  wire logic signed [31:0] push_value,
	output logic                    done,
	output logic signed [31:0]      pop_value,
	output logic [1:0]              status
);

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	deq_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.push_value(push_value),
		.pop_value (pop_value),
		.status    (status)
	);

endmodule
`default_nettype wire
